// ===== design/rayleigh_quotient_assert.svh =====
// ----------------------------------------------------------------------------
// Rayleigh quotient assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RAYLEIGH_QUOTIENT_ASSERT_SVH
`define RAYLEIGH_QUOTIENT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rayleigh_quotient: same-cycle check failed");

// next-cycle implication, disabled in reset
`define RQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rayleigh_quotient: next-cycle check failed");

`endif

// ===== design/rq_pkg.sv =====
// ----------------------------------------------------------------------------
// rq_pkg
// Word types, opcodes and controller states of the Rayleigh quotient block.
// ----------------------------------------------------------------------------
package rq_pkg;

    typedef enum logic [1:0] {
        OP_WR_MATRIX = 2'd0,
        OP_WR_VECTOR = 2'd1,
        OP_COMPUTE   = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_DIV,
        ST_HOLD
    } rq_state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         row_index;
        logic [2:0]         column_index;
        logic signed [15:0] entry_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] quotient;
        logic               zero_vector;
    } out_word_t;

    // store write broadcast to the cells and the tail
    typedef struct packed {
        logic               mat_we;
        logic               vec_we;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] value;
    } load_cmd_t;

endpackage

// ===== design/rq_cell.sv =====
// ----------------------------------------------------------------------------
// rq_cell
// One column of A and one entry of x; adds A[i][j]*x[j] to the passing row sum.
// ----------------------------------------------------------------------------
module rq_cell #(
    parameter int MAX_ORDER = 8,
    parameter int CELL_IDX  = 0,
    parameter int IDX_W     = 3,
    parameter int NW        = 4,
    parameter int ACC_W     = 35
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rq_pkg::load_cmd_t       load,
    input  logic [NW-1:0]           order,
    input  logic                    link_valid,
    input  logic [IDX_W-1:0]        link_row,
    input  logic signed [ACC_W-1:0] link_sum,
    output logic                    pass_valid,
    output logic [IDX_W-1:0]        pass_row,
    output logic signed [ACC_W-1:0] pass_sum
);

    logic signed [15:0]      col_mem [MAX_ORDER];
    logic signed [15:0]      x_reg;
    logic [IDX_W-1:0]        wr_row;
    logic signed [31:0]      prod;
    logic                    active;
    logic                    valid_reg;
    logic [IDX_W-1:0]        row_reg;
    logic signed [ACC_W-1:0] sum_reg;
    logic signed [ACC_W-1:0] sum_next;

    assign wr_row = IDX_W'(load.row);

    // store column entries and the vector entry of this cell
    always_ff @(posedge clk)
    begin
        if (load.mat_we && int'(load.col) == CELL_IDX && int'(load.row) < MAX_ORDER)
        begin
            col_mem[wr_row] <= load.value;
        end
        if (load.vec_we && int'(load.row) == CELL_IDX)
        begin
            x_reg <= load.value;
        end
    end

    // multiply and add; cells beyond the order add nothing
    always_comb
    begin
        active   = CELL_IDX < int'(order);
        prod     = col_mem[link_row] * x_reg;
        sum_next = active ? link_sum + ACC_W'(prod) : link_sum;
    end

    // advance the row sum to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= link_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= link_row;
        sum_reg <= sum_next;
    end

    assign pass_valid = valid_reg;
    assign pass_row   = row_reg;
    assign pass_sum   = sum_reg;

endmodule

// ===== design/rq_tail.sv =====
// ----------------------------------------------------------------------------
// rq_tail
// Forms x[i]*y[i] and x[i]*x[i] and accumulates numerator and denominator.
// ----------------------------------------------------------------------------
module rq_tail #(
    parameter int MAX_ORDER = 8,
    parameter int IDX_W     = 3,
    parameter int ACC_W     = 35,
    parameter int NUM_W     = 54,
    parameter int DEN_W     = 35
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rq_pkg::load_cmd_t       load,
    input  logic                    clear,
    input  logic                    row_valid,
    input  logic [IDX_W-1:0]        row_idx,
    input  logic signed [ACC_W-1:0] row_sum,
    output logic                    acc_valid,
    output logic signed [NUM_W-1:0] num_sum,
    output logic [DEN_W-1:0]        den_sum
);

    localparam int LO_W = 17;
    localparam int HI_W = ACC_W - LO_W;

    logic signed [15:0]          vec_mem [MAX_ORDER];
    logic signed [15:0]          x_sel;
    logic signed [HI_W-1:0]      y_hi;
    logic signed [LO_W:0]        y_lo;
    logic signed [15+HI_W:0]     p_hi_next;
    logic signed [16+LO_W:0]     p_lo_next;
    logic signed [31:0]          p_xx_next;
    logic signed [15+HI_W:0]     p_hi_reg;
    logic signed [16+LO_W:0]     p_lo_reg;
    logic signed [31:0]          p_xx_reg;
    logic                        valid_reg;
    logic signed [NUM_W-1:0]     hi_ext;
    logic signed [NUM_W-1:0]     num_reg;
    logic signed [NUM_W-1:0]     num_next;
    logic [DEN_W-1:0]            den_reg;
    logic [DEN_W-1:0]            den_next;

    // keep a copy of x for the row-side factor
    always_ff @(posedge clk)
    begin
        if (load.vec_we && int'(load.row) < MAX_ORDER)
        begin
            vec_mem[IDX_W'(load.row)] <= load.value;
        end
    end

    // split y so each product stays narrow
    always_comb
    begin
        x_sel     = vec_mem[row_idx];
        y_hi      = row_sum[ACC_W-1:LO_W];
        y_lo      = $signed({1'b0, row_sum[LO_W-1:0]});
        p_hi_next = x_sel * y_hi;
        p_lo_next = x_sel * y_lo;
        p_xx_next = x_sel * x_sel;
    end

    always_ff @(posedge clk)
    begin
        p_hi_reg <= p_hi_next;
        p_lo_reg <= p_lo_next;
        p_xx_reg <= p_xx_next;
    end

    // recombine partial products and accumulate
    always_comb
    begin
        hi_ext   = NUM_W'(p_hi_reg);
        num_next = num_reg + (hi_ext <<< LO_W) + NUM_W'(p_lo_reg);
        den_next = den_reg + DEN_W'($unsigned(p_xx_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            num_reg   <= '0;
            den_reg   <= '0;
        end
        else
        begin
            valid_reg <= row_valid;
            if (clear)
            begin
                num_reg <= '0;
                den_reg <= '0;
            end
            else if (valid_reg)
            begin
                num_reg <= num_next;
                den_reg <= den_next;
            end
        end
    end

    assign acc_valid = valid_reg;
    assign num_sum   = num_reg;
    assign den_sum   = den_reg;

endmodule

// ===== design/rq_div.sv =====
// ----------------------------------------------------------------------------
// rq_div
// Restoring divider, one quotient bit per cycle, with sign and saturation.
// ----------------------------------------------------------------------------
module rq_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 35
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [31:0]      quotient
);

    localparam int DVD_W = NUM_W + 4;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W:0]   rem_next;

    // magnitude of the numerator; wraps correctly for the most negative value
    assign mag = NUM_W'($unsigned(num[NUM_W-1] ? -num : num));

    // one restoring step
    always_comb
    begin
        rem_sh   = {rem_reg[DEN_W-1:0], dvd_reg[DVD_W-1]};
        fits     = rem_sh >= {1'b0, den_reg};
        rem_next = fits ? rem_sh - {1'b0, den_reg} : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && cnt_reg == CNT_W'(1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            dvd_reg <= {mag, 4'b0000};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[DVD_W-2:0], fits};
        end
    end

    // apply sign and clamp to the Q28.4 range
    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg > DVD_W'(33'h0_8000_0000))
            begin
                quotient = 32'sh8000_0000;
            end
            else
            begin
                quotient = $signed(32'(0 - q_reg[31:0]));
            end
        end
        else
        begin
            if (q_reg > DVD_W'(32'h7FFF_FFFF))
            begin
                quotient = 32'sh7FFF_FFFF;
            end
            else
            begin
                quotient = $signed(q_reg[31:0]);
            end
        end
    end

    assign done = done_reg;

endmodule

// ===== design/rayleigh_quotient.sv =====
// ----------------------------------------------------------------------------
// rayleigh_quotient: (x.Ax)/(x.x) in Q28.4 over a chain of column cells
// Load words are accepted one per cycle back to back while the sequencer is idle.
// Compute word: the N rows are fed, pass MAX_ORDER cell stages plus the tail,
// then NUM_W+4 divider steps run before the result word is loaded;
// a zero vector skips the divider.
// Reset clears control and sets size_reg to 8; stores hold no reset value.
// ----------------------------------------------------------------------------
module rayleigh_quotient #(
    parameter int MAX_ORDER = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rq_pkg::in_word_t    in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output rq_pkg::out_word_t   out_word,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_data
);

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int NW    = $clog2(MAX_ORDER + 1);
    localparam int ACC_W = 32 + $clog2(MAX_ORDER);
    localparam int NUM_W = 16 + ACC_W + $clog2(MAX_ORDER);
    localparam int DEN_W = 32 + $clog2(MAX_ORDER);

    rq_pkg::rq_state_t       state_reg;
    rq_pkg::rq_state_t       state_next;
    logic [3:0]              size_reg;
    logic [NW-1:0]           order;
    logic [NW-1:0]           feed_cnt_reg;
    logic [NW-1:0]           feed_cnt_next;
    logic [NW-1:0]           done_cnt_reg;
    logic [NW-1:0]           done_cnt_next;
    logic                    zero_reg;
    logic                    zero_next;
    logic                    accept;
    logic                    compute_go;
    logic                    feed_valid;
    logic                    div_start;
    logic                    out_load;
    logic                    out_valid_reg;
    rq_pkg::out_word_t       out_word_reg;
    rq_pkg::load_cmd_t       load;
    logic                    link_valid [MAX_ORDER+1];
    logic [IDX_W-1:0]        link_row   [MAX_ORDER+1];
    logic signed [ACC_W-1:0] link_sum   [MAX_ORDER+1];
    logic                    acc_valid;
    logic signed [NUM_W-1:0] num_sum;
    logic [DEN_W-1:0]        den_sum;
    logic                    div_done;
    logic signed [31:0]      div_quot;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_data;
        end
    end

    // clamp the order to 1..MAX_ORDER
    always_comb
    begin
        if (size_reg == 4'd0)
        begin
            order = NW'(1);
        end
        else if (int'(size_reg) > MAX_ORDER)
        begin
            order = NW'(MAX_ORDER);
        end
        else
        begin
            order = NW'(size_reg);
        end
    end

    // decode accepted words into store writes
    always_comb
    begin
        accept       = in_valid && !in_stall;
        compute_go   = accept && in_word.opcode == rq_pkg::OP_COMPUTE;
        load.mat_we  = accept && in_word.opcode == rq_pkg::OP_WR_MATRIX;
        load.vec_we  = accept && in_word.opcode == rq_pkg::OP_WR_VECTOR;
        load.row     = in_word.row_index;
        load.col     = in_word.column_index;
        load.value   = in_word.entry_value;
    end

    // sequencer: feed rows, drain the chain, divide, deliver
    always_comb
    begin
        state_next    = state_reg;
        feed_cnt_next = feed_cnt_reg;
        done_cnt_next = acc_valid ? done_cnt_reg + NW'(1) : done_cnt_reg;
        zero_next     = zero_reg;
        in_stall      = 1'b1;
        feed_valid    = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            rq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (compute_go)
                begin
                    feed_cnt_next = '0;
                    done_cnt_next = '0;
                    state_next    = rq_pkg::ST_FEED;
                end
            end
            rq_pkg::ST_FEED:
            begin
                feed_valid    = 1'b1;
                feed_cnt_next = feed_cnt_reg + NW'(1);
                if (feed_cnt_reg == order - NW'(1))
                begin
                    state_next = rq_pkg::ST_DRAIN;
                end
            end
            rq_pkg::ST_DRAIN:
            begin
                if (done_cnt_reg == order)
                begin
                    zero_next = den_sum == '0;
                    if (den_sum == '0)
                    begin
                        state_next = rq_pkg::ST_HOLD;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = rq_pkg::ST_DIV;
                    end
                end
            end
            rq_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = rq_pkg::ST_HOLD;
                end
            end
            rq_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = rq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rq_pkg::ST_IDLE;
            feed_cnt_reg <= '0;
            done_cnt_reg <= '0;
            zero_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            feed_cnt_reg <= feed_cnt_next;
            done_cnt_reg <= done_cnt_next;
            zero_reg     <= zero_next;
        end
    end

    // head of the chain
    assign link_valid[0] = feed_valid;
    assign link_row[0]   = IDX_W'(feed_cnt_reg);
    assign link_sum[0]   = '0;

    // row of column cells
    for (genvar j = 0; j < MAX_ORDER; j++)
    begin : g_cell
        rq_cell #(
            .MAX_ORDER (MAX_ORDER),
            .CELL_IDX  (j),
            .IDX_W     (IDX_W),
            .NW        (NW),
            .ACC_W     (ACC_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (load),
            .order      (order),
            .link_valid (link_valid[j]),
            .link_row   (link_row[j]),
            .link_sum   (link_sum[j]),
            .pass_valid (link_valid[j+1]),
            .pass_row   (link_row[j+1]),
            .pass_sum   (link_sum[j+1])
        );
    end

    rq_tail #(
        .MAX_ORDER (MAX_ORDER),
        .IDX_W     (IDX_W),
        .ACC_W     (ACC_W),
        .NUM_W     (NUM_W),
        .DEN_W     (DEN_W)
    ) u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .clear     (compute_go),
        .row_valid (link_valid[MAX_ORDER]),
        .row_idx   (link_row[MAX_ORDER]),
        .row_sum   (link_sum[MAX_ORDER]),
        .acc_valid (acc_valid),
        .num_sum   (num_sum),
        .den_sum   (den_sum)
    );

    rq_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_sum),
        .den      (den_sum),
        .done     (div_done),
        .quotient (div_quot)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg.quotient    <= zero_reg ? 32'sd0 : div_quot;
            out_word_reg.zero_vector <= zero_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`include "rayleigh_quotient_assert.svh"

    `RQ_ASSERT_NOW(a_out_from_hold, $rose(out_valid_reg), $past(state_reg == rq_pkg::ST_HOLD))
    `RQ_ASSERT_NOW(a_done_bounded, state_reg == rq_pkg::ST_DRAIN, done_cnt_reg <= order)
    `RQ_ASSERT_NEXT(a_compute_starts, compute_go, state_reg == rq_pkg::ST_FEED && feed_cnt_reg == '0)

endmodule

// ===== dv/rayleigh_quotient_tb.sv =====
// ----------------------------------------------------------------------------
// Rayleigh quotient testbench
// Loads matrices and vectors, issues compute words at several orders, and
// checks every quotient and zero-vector flag against an in-bench predictor.
// ----------------------------------------------------------------------------
module rayleigh_quotient_tb;

    localparam int ORDER_MAX = 8;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    rq_pkg::in_word_t   in_word;
    logic               out_valid;
    logic               out_stall;
    rq_pkg::out_word_t  out_word;
    logic               cfg_we;
    logic [3:0]         cfg_data;

    rayleigh_quotient #(.MAX_ORDER(ORDER_MAX)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [15:0] mat_copy [ORDER_MAX*ORDER_MAX];
    logic signed [15:0] vec_copy [ORDER_MAX];
    logic [3:0]         order_reg;

    rq_pkg::in_word_t  pending_words [$];
    rq_pkg::out_word_t expected_quotients [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int mismatch_count;
    int checked_count;
    int zero_vec_count;
    int sat_count;
    int sent_count;
    bit in_fire;

    // Compute (x.Ax)/(x.x) in Q28.4 for the current stores and order
    function automatic rq_pkg::out_word_t predict_quotient();
        int unsigned        n;
        logic signed [63:0] row_sum;
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic [63:0]        mag;
        logic [63:0]        q;
        rq_pkg::out_word_t  res;
        n = (order_reg == 0) ? 1 : ((order_reg > ORDER_MAX) ? ORDER_MAX : order_reg);
        num = 0;
        den = 0;
        for (int i = 0; i < n; i++)
        begin
            row_sum = 0;
            for (int j = 0; j < n; j++)
                row_sum += 64'(mat_copy[i*ORDER_MAX+j]) * 64'(vec_copy[j]);
            num += 64'(vec_copy[i]) * row_sum;
            den += 64'(vec_copy[i]) * 64'(vec_copy[i]);
        end
        res = '0;
        if (den == 0)
        begin
            res.zero_vector = 1'b1;
            return res;
        end
        mag = (num < 0) ? -num : num;
        q = (mag << 4) / den;
        if (num < 0)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            res.quotient = 32'(-q);
        end
        else
        begin
            if (q > 64'h7FFF_FFFF)
                q = 64'h7FFF_FFFF;
            res.quotient = q[31:0];
        end
        return res;
    endfunction

    // Apply one accepted word to the predictor
    function automatic void apply_word(rq_pkg::in_word_t w);
        rq_pkg::out_word_t r;
        case (rq_pkg::op_t'(w.opcode))
            rq_pkg::OP_WR_MATRIX:
                mat_copy[w.row_index*ORDER_MAX + w.column_index] = w.entry_value;
            rq_pkg::OP_WR_VECTOR: vec_copy[w.row_index] = w.entry_value;
            rq_pkg::OP_COMPUTE:
            begin
                r = predict_quotient();
                if (r.zero_vector)
                    zero_vec_count++;
                if (!r.zero_vector && (r.quotient == 32'h7FFF_FFFF ||
                                       r.quotient == 32'h8000_0000))
                    sat_count++;
                expected_quotients.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic rq_pkg::in_word_t make_word(rq_pkg::op_t op, int r, int c, int v);
        rq_pkg::in_word_t w;
        w.opcode = op;
        w.row_index = r[2:0];
        w.column_index = c[2:0];
        w.entry_value = v[15:0];
        return w;
    endfunction

    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 8191)) - 4096);
            3: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue a full load of the active block and a compute
    task automatic queue_full_set(int n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                pending_words.push_back(make_word(rq_pkg::OP_WR_MATRIX, i, j, rand_entry()));
        for (int i = 0; i < n; i++)
            pending_words.push_back(make_word(rq_pkg::OP_WR_VECTOR, i, $urandom, rand_entry()));
        pending_words.push_back(make_word(rq_pkg::OP_COMPUTE, $urandom, $urandom, $urandom));
    endtask

    // Fill every store entry so no unwritten read can occur at any order
    task automatic queue_fill_all();
        for (int i = 0; i < ORDER_MAX; i++)
            for (int j = 0; j < ORDER_MAX; j++)
                pending_words.push_back(make_word(rq_pkg::OP_WR_MATRIX, i, j, rand_entry()));
        for (int i = 0; i < ORDER_MAX; i++)
            pending_words.push_back(make_word(rq_pkg::OP_WR_VECTOR, i, 0, rand_entry()));
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_quotients.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_order(logic [3:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        order_reg = val;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drive one word per acceptance; advance only on handshake
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_fire)
            begin
                // hold the word that has not been taken yet
            end
            else if (pending_words.size() != 0 &&
                     $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_word  <= pending_words[0];
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Pop the driven word at the edge where it is taken
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            apply_word(pending_words.pop_front());
            sent_count++;
        end
    end

    // Receiver stall, with a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        rq_pkg::out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_quotients.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: quotient=%h zero_vector=%b",
                             out_word.quotient, out_word.zero_vector);
            end
            else
            begin
                exp_w = expected_quotients.pop_front();
                checked_count++;
                if (out_word.quotient !== exp_w.quotient ||
                    out_word.zero_vector !== exp_w.zero_vector)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: quotient exp %h got %h, zero_vector exp %b got %b",
                                 exp_w.quotient, out_word.quotient,
                                 exp_w.zero_vector, out_word.zero_vector);
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 4'd0;
        hold_off_cycles = 0;
        send_idle_pct = 14;
        recv_idle_pct = 48;
        mismatch_count = 0;
        checked_count = 0;
        zero_vec_count = 0;
        sat_count = 0;
        sent_count = 0;
        in_fire = 1'b0;
        order_reg = 4'd8;
        for (int i = 0; i < ORDER_MAX*ORDER_MAX; i++)
            mat_copy[i] = '0;
        for (int i = 0; i < ORDER_MAX; i++)
            vec_copy[i] = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: all-max and all-min sets at full order, zero vector, opcode 3
        for (int i = 0; i < ORDER_MAX; i++)
            for (int j = 0; j < ORDER_MAX; j++)
                pending_words.push_back(make_word(rq_pkg::OP_WR_MATRIX, i, j, 32767));
        for (int i = 0; i < ORDER_MAX; i++)
            pending_words.push_back(make_word(rq_pkg::OP_WR_VECTOR, i, 7, -32768));
        pending_words.push_back(make_word(rq_pkg::OP_COMPUTE, 7, 7, -1));
        pending_words.push_back(make_word(rq_pkg::OP_NONE, 7, 7, 16'h7FFF));
        pending_words.push_back(make_word(rq_pkg::OP_NONE, 0, 0, 16'h8000));
        for (int i = 0; i < ORDER_MAX; i++)
            pending_words.push_back(make_word(rq_pkg::OP_WR_VECTOR, i, 0, 0));
        pending_words.push_back(make_word(rq_pkg::OP_COMPUTE, 0, 0, 0));
        wait_drained();

        // tiny order with a lone element, then out-of-range size values
        write_order(4'd1);
        pending_words.push_back(make_word(rq_pkg::OP_WR_MATRIX, 0, 0, -32768));
        pending_words.push_back(make_word(rq_pkg::OP_WR_VECTOR, 0, 0, 1));
        pending_words.push_back(make_word(rq_pkg::OP_COMPUTE, 0, 0, 0));
        wait_drained();
        write_order(4'd0);
        pending_words.push_back(make_word(rq_pkg::OP_COMPUTE, 0, 0, 0));
        wait_drained();
        write_order(4'd15);
        queue_fill_all();
        pending_words.push_back(make_word(rq_pkg::OP_COMPUTE, 0, 0, 0));
        wait_drained();

        // random phases over orders, changing the idle pattern
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 14;
            end
            if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_order((ph == 0) ? 4'd8 : 4'($urandom_range(1, 8)));
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    pending_words.push_back(make_word(rq_pkg::op_t'($urandom_range(0, 3)),
                                            $urandom, $urandom, $urandom));
                else
                    queue_full_set((order_reg == 0) ? 1 :
                                   (order_reg > 8 ? 8 : order_reg));
            end
            if (ph == 6)
            begin
                // back-to-back computes with the receiver held off
                for (int k = 0; k < 12; k++)
                    pending_words.push_back(make_word(rq_pkg::OP_COMPUTE, 0, 0, 0));
                hold_off_cycles = 600;
            end
            wait_drained();
        end

        $display("covered %0d words, %0d quotients checked (%0d zero-vector, %0d saturated)",
                 sent_count, checked_count, zero_vec_count, sat_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
